@@ rtl/phcr_pkg.sv @@
package phcr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_THRESH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_RANGE   = 3'd5;

  localparam logic [15:0] SETPOINT_RST   = 16'd0;
  localparam logic [15:0] GAIN_P_RST     = 16'd256;
  localparam logic [15:0] GAIN_I_RST     = 16'd26;
  localparam logic [15:0] ERR_THRESH_RST = 16'd100;
  localparam logic [7:0]  ERR_LIMIT_RST  = 8'd10;
  localparam logic [15:0] PWM_RANGE_RST  = 16'd1023;

  localparam int INTEG_W = 32;
  localparam int ERR_W   = 17;

  typedef struct packed {
    logic [15:0] measured;
    logic        active;
  } phcr_in_t;

  typedef struct packed {
    logic [15:0] pwm_value;
    logic        pwm_update;
    logic        broken_event;
    logic        wire_good;
  } phcr_out_t;

endpackage

@@ rtl/pi_heater_current_regulator.sv @@
// PI regulator for a heated-wire current with conditional-integration anti-windup
// and a fault detector for a wire whose error keeps growing.
// Input channel: in_valid, in_stall, in_data (measured value and active flag).
// Each input beat yields exactly one result beat on out_valid, out_stall, out_data.
// Configuration: cfg_we, cfg_idx, cfg_wdata; write only while the block is idle.
// An accepted beat is held in an input register; from there the error, both gain
// products, the clamp and the integral update are computed combinationally and
// loaded into the result register. Throughput is one beat per cycle while the
// receiver does not stall; the regulator state is updated as each beat moves
// into the result register, so consecutive beats see it at once.
// When the receiver stalls, the result register holds its beat and the input
// register keeps a second one; in_stall then rises until the result is taken.
// A synchronous reset (rst_n low) restores the default registers, clears the
// integral, previous error and fault count, and marks the wire good.
module pi_heater_current_regulator
  import phcr_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  phcr_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output phcr_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW = 35;

  logic [15:0] setpoint_r, kp_r, ki_r, thresh_r, range_r;
  logic [7:0]  limit_r;

  logic                     s1_valid_r;
  phcr_in_t                 s1_data_r;
  logic                     out_valid_r;
  phcr_out_t                out_data_r, out_data_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0]  prev_err_r, prev_err_nxt;
  logic [7:0]               count_r, count_nxt;
  logic                     health_r, health_nxt;

  logic                     advance, fire;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         abs_err, prev_abs;
  logic                     growing, fault;
  logic signed [33:0]       p_prod, i_prod;
  logic signed [SW-1:0]     sum, top, clamped, i_sum;
  logic                     was_clamped, same_sign;
  logic signed [INTEG_W-1:0] integ_sat;

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= SETPOINT_RST;
      kp_r       <= GAIN_P_RST;
      ki_r       <= GAIN_I_RST;
      thresh_r   <= ERR_THRESH_RST;
      limit_r    <= ERR_LIMIT_RST;
      range_r    <= PWM_RANGE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SETPOINT:   setpoint_r <= cfg_wdata;
        REG_GAIN_P:     kp_r       <= cfg_wdata;
        REG_GAIN_I:     ki_r       <= cfg_wdata;
        REG_ERR_THRESH: thresh_r   <= cfg_wdata;
        REG_ERR_LIMIT:  limit_r    <= cfg_wdata[7:0];
        REG_PWM_RANGE:  range_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    err      = $signed({1'b0, setpoint_r}) - $signed({1'b0, s1_data_r.measured});
    abs_err  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    prev_abs = prev_err_r[ERR_W-1] ? ERR_W'(-prev_err_r) : ERR_W'(prev_err_r);
    growing  = (abs_err >= prev_abs) && (abs_err > {1'b0, thresh_r});
    fault    = growing && (count_r >= limit_r);

    p_prod = 34'(err) * 34'($signed({1'b0, kp_r}));
    i_prod = 34'(err) * 34'($signed({1'b0, ki_r}));
    sum    = SW'(p_prod) + SW'(integ_r);
    top    = $signed(SW'(range_r)) <<< FRAC_BITS;
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > top) begin
      clamped = top;
    end else begin
      clamped = sum;
    end
    was_clamped = (sum < 0) || (sum > top);
    same_sign   = (err > 0 && integ_r > 0) || (err < 0 && integ_r < 0);

    i_sum = SW'(i_prod) + SW'(integ_r);
    if ((&i_sum[SW-1:INTEG_W-1]) || !(|i_sum[SW-1:INTEG_W-1])) begin
      integ_sat = i_sum[INTEG_W-1:0];
    end else if (i_sum[SW-1]) begin
      integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
    end

    integ_nxt    = integ_r;
    prev_err_nxt = prev_err_r;
    count_nxt    = count_r;
    health_nxt   = health_r;
    out_data_nxt.pwm_value    = '0;
    out_data_nxt.pwm_update   = 1'b0;
    out_data_nxt.broken_event = 1'b0;
    out_data_nxt.wire_good    = health_r;

    if (s1_data_r.active) begin
      if (growing) begin
        prev_err_nxt = err;
      end
      if (fault) begin
        count_nxt  = '0;
        health_nxt = 1'b0;
        out_data_nxt.broken_event = 1'b1;
        out_data_nxt.wire_good    = 1'b0;
      end else begin
        count_nxt = growing ? count_r + 8'd1 : '0;
        if (!(was_clamped && same_sign)) begin
          integ_nxt = integ_sat;
        end
        out_data_nxt.pwm_value  = clamped[FRAC_BITS +: 16];
        out_data_nxt.pwm_update = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_err_r  <= '0;
      count_r     <= '0;
      health_r    <= 1'b1;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        integ_r    <= integ_nxt;
        prev_err_r <= prev_err_nxt;
        count_r    <= count_nxt;
        health_r   <= health_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Once the wire is declared broken it stays so until reset.
  a_health_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !health_r |=> !health_r)
    else $error("health flag recovered without reset");

  a_update_xor_broken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.pwm_update && out_data_r.broken_event))
    else $error("drive update on a fault beat");

  a_idle_pwm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.pwm_update) |-> (out_data_r.pwm_value == '0))
    else $error("drive value without update");

  a_broken_not_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.broken_event) |-> !out_data_r.wire_good)
    else $error("fault beat reports a good wire");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with no beat held");

endmodule

@@ verif/pi_heater_current_regulator_tb.sv @@
`timescale 1ns / 1ps

module pi_heater_current_regulator_tb;
  import phcr_pkg::*;

  localparam int FRAC = 8;
  localparam longint INTEG_MAX = (64'sd1 <<< 31) - 1;
  localparam longint INTEG_MIN = -(64'sd1 <<< 31);

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  phcr_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  phcr_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pi_heater_current_regulator #(.FRAC_BITS(FRAC)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Regulator settings and state as the testbench expects them.
  logic [15:0] set_mv     = SETPOINT_RST;
  logic [15:0] kp         = GAIN_P_RST;
  logic [15:0] ki         = GAIN_I_RST;
  logic [15:0] err_thresh = ERR_THRESH_RST;
  logic [7:0]  err_limit  = ERR_LIMIT_RST;
  logic [15:0] pwm_top    = PWM_RANGE_RST;
  longint      integ      = 0;
  longint      last_err   = 0;
  logic [7:0]  drift_count = '0;
  logic        healthy    = 1'b1;

  phcr_out_t pending_results[$];
  int mismatches  = 0;
  int ticks_seen  = 0;
  int active_seen = 0;
  int faults_seen = 0;
  int drives_seen = 0;
  int settings    = 0;

  int gap_max    = 0;
  int burst_left = 0;
  int stall_pct  = 0;
  int stall_run  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic phcr_out_t regulate_tick(input phcr_in_t t);
    phcr_out_t r;
    longint err, err_mag, prev_mag, sum, top, clamped, next_integ;
    bit hold;
    r = '0;
    r.wire_good = healthy;
    if (!t.active) return r;
    err = longint'(set_mv) - longint'(t.measured);
    err_mag = (err < 0) ? -err : err;
    prev_mag = (last_err < 0) ? -last_err : last_err;
    if (err_mag >= prev_mag && err_mag > longint'(err_thresh)) begin
      last_err = err;
      if (drift_count >= err_limit) begin
        drift_count = '0;
        healthy = 1'b0;
        r.broken_event = 1'b1;
        r.wire_good = 1'b0;
        return r;
      end
      drift_count = drift_count + 8'd1;
    end else begin
      drift_count = '0;
    end
    sum = err * longint'(kp) + integ;
    top = longint'(pwm_top) <<< FRAC;
    clamped = sum;
    if (clamped < 0) clamped = 0;
    if (clamped > top) clamped = top;
    hold = (clamped != sum) && ((err > 0 && integ > 0) || (err < 0 && integ < 0));
    if (!hold) begin
      next_integ = integ + longint'(ki) * err;
      if (next_integ > INTEG_MAX) next_integ = INTEG_MAX;
      if (next_integ < INTEG_MIN) next_integ = INTEG_MIN;
      integ = next_integ;
    end
    r.pwm_value = 16'(clamped >>> FRAC);
    r.pwm_update = 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic logic [15:0] extreme_or_random();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (stall_run == 0) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      stall_run <= $urandom_range(1, 6);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // Output beats are checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin : result_check
    phcr_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: %h", out_data);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.pwm_value !== want.pwm_value) begin
            $error("pwm_value: expected %0d, got %0d", want.pwm_value, out_data.pwm_value);
            mismatches++;
          end
          if (out_data.pwm_update !== want.pwm_update) begin
            $error("pwm_update: expected %0b, got %0b", want.pwm_update, out_data.pwm_update);
            mismatches++;
          end
          if (out_data.broken_event !== want.broken_event) begin
            $error("broken_event: expected %0b, got %0b", want.broken_event,
                   out_data.broken_event);
            mismatches++;
          end
          if (out_data.wire_good !== want.wire_good) begin
            $error("wire_good: expected %0b, got %0b", want.wire_good, out_data.wire_good);
            mismatches++;
          end
          if (want.broken_event) faults_seen++;
          if (want.pwm_update) drives_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(regulate_tick(in_data));
        ticks_seen++;
        if (in_data.active) active_seen++;
      end
    end
  end

  task automatic send_tick(input logic [15:0] mv, input logic act);
    if (gap_max > 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= phcr_in_t'{measured: mv, active: act};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] sp, input logic [15:0] gp,
                           input logic [15:0] gi, input logic [15:0] thr,
                           input logic [7:0] lim, input logic [15:0] rng);
    logic [CFG_IDX_W-1:0] regs [6];
    logic [15:0]          vals [6];
    logic [7:0]           junk;
    junk = 8'($urandom);
    regs = '{REG_SETPOINT, REG_GAIN_P, REG_GAIN_I, REG_ERR_THRESH, REG_ERR_LIMIT,
             REG_PWM_RANGE};
    vals = '{sp, gp, gi, thr, {junk, lim}, rng};
    for (int k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    set_mv = sp;
    kp = gp;
    ki = gi;
    err_thresh = thr;
    err_limit = lim;
    pwm_top = rng;
    settings++;
  endtask

  // Each segment starts at least as far out as the last counted error and then
  // moves steadily away from the setpoint, so past the threshold the count climbs.
  task automatic drift_run(input int items, input int seg_min, input int seg_max,
                           input int step_max, input logic [15:0] sp);
    longint mv;
    int seg_left, dir, offset, stride;
    seg_left = 0;
    mv = longint'(sp);
    dir = 1;
    for (int k = 0; k < items; k++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(seg_min, seg_max);
        offset = int'((last_err < 0) ? -last_err : last_err);
        stride = $urandom_range(0, 40);
        offset = offset + stride;
        dir = $urandom_range(1) ? 1 : -1;
        if ((dir > 0 && longint'(sp) + offset >= 65535) ||
            (dir < 0 && offset >= int'(sp))) begin
          dir = -dir;
        end
        mv = longint'(clip16(longint'(sp) + offset * dir));
      end else begin
        stride = $urandom_range(0, step_max);
        mv = longint'(clip16(mv + stride * dir));
      end
      seg_left--;
      send_tick(16'(mv), $urandom_range(19) != 0);
    end
  endtask

  task automatic test_reset_defaults();
    gap_max = 0;
    stall_pct = 0;
    send_tick(16'd0, 1'b1);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd50, 1'b1);
    wait_drained();
  endtask

  task automatic test_extremes();
    gap_max = 3;
    stall_pct = 40;
    // Full positive error drives the integral into its upper limit, then holds it.
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF);
    send_tick(16'd0, 1'b1);
    send_tick(16'd0, 1'b1);
    send_tick(16'hFFFF, 1'b1);
    wait_drained();
    configure(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF);
    send_tick(16'hFFFF, 1'b1);
    send_tick(16'hFFFF, 1'b1);
    wait_drained();
    configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 16'h0000);
    send_tick(16'd0, 1'b1);
    wait_drained();
  endtask

  task automatic test_fault_detection();
    gap_max = 0;
    stall_pct = 20;
    configure(16'd1000, 16'd256, 16'd26, 16'd50, 8'd2, 16'd1023);
    send_tick(16'd900, 1'b1);
    send_tick(16'd880, 1'b1);
    send_tick(16'd860, 1'b1);
    send_tick(16'd860, 1'b1);
    send_tick(16'd990, 1'b1);
    send_tick(16'd12345, 1'b0);
    wait_drained();
    configure(16'd1000, 16'd256, 16'd26, 16'd50, 8'd0, 16'd1023);
    send_tick(16'd2000, 1'b1);
    wait_drained();
  endtask

  task automatic test_regulation();
    logic [15:0] sp;
    int noise;
    for (int half = 0; half < 2; half++) begin
      gap_max = half ? 6 : 0;
      stall_pct = half ? 50 : 0;
      sp = 16'($urandom);
      configure(sp, 16'($urandom_range(64, 1024)), 16'($urandom_range(0, 128)),
                16'($urandom_range(200, 2000)), 8'($urandom_range(5, 40)),
                16'($urandom_range(64, 4095)));
      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(15) == 0) noise = $urandom_range(0, 8000);
        else noise = $urandom_range(0, 300);
        if ($urandom_range(1)) noise = -noise;
        send_tick(clip16(longint'(sp) + noise), $urandom_range(9) != 0);
        // The sender holds off once here until every result is back.
        if (half == 1 && k == 60) wait_drained();
      end
      wait_drained();
    end
  endtask

  task automatic test_drift();
    logic [15:0] sp;
    gap_max = 3;
    stall_pct = 30;
    for (int n = 0; n < 2; n++) begin
      sp = 16'($urandom_range(20000, 45000));
      configure(sp, 16'($urandom_range(0, 2048)), 16'($urandom_range(0, 256)),
                16'($urandom_range(0, 300)), 8'($urandom_range(0, 3) * 3),
                16'($urandom));
      drift_run(75, 3, 30, 60, sp);
      wait_drained();
    end
  endtask

  task automatic test_long_drift();
    logic [15:0] sp;
    gap_max = 4;
    stall_pct = 60;
    sp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    configure(sp, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 20)), 8'd255,
              16'($urandom));
    drift_run(300, 300, 300, 2, sp);
    wait_drained();
  endtask

  task automatic test_random_noise();
    for (int n = 0; n < 4; n++) begin
      gap_max = 8;
      stall_pct = (n % 2) ? 70 : 0;
      configure(extreme_or_random(), extreme_or_random(), extreme_or_random(),
                extreme_or_random(), 8'(extreme_or_random()), extreme_or_random());
      for (int k = 0; k < 50; k++) begin
        send_tick(16'($urandom), 1'($urandom_range(1)));
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_extremes();
    test_fault_detection();
    test_regulation();
    test_drift();
    test_long_drift();
    test_random_noise();
    repeat (8) @(posedge clk);
    $display("Run covered %0d ticks, %0d of them active, under %0d register settings.",
             ticks_seen, active_seen, settings);
    $display("It saw %0d drive updates and %0d wire fault declarations.",
             drives_seen, faults_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ pi_heater_current_regulator.f @@
rtl/phcr_pkg.sv
rtl/pi_heater_current_regulator.sv
verif/pi_heater_current_regulator_tb.sv
